// File: design/rgb_to_yxy_converter_defines.svh
// Assertion macros for the RGB to xyY converter checker.
// Included by the checker file; needs a signal named clock and one named reset in scope.
`ifndef RGB_TO_YXY_CONVERTER_DEFINES_SVH
`define RGB_TO_YXY_CONVERTER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define RYC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define RYC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Same-cycle implication, checked through reset too.
`define RYC_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: design/ryc_pkg.sv
// Shared widths, matrix coefficients and the divider cell word for the RGB to xyY converter.
// No dependencies.
package ryc_pkg;

   localparam int CH_W   = 8;   // input channel width
   localparam int RAW_W  = 24;  // one row sum of coefficient * channel
   localparam int SUM_W  = 26;  // X + Y + Z raw sum
   localparam int Q_W    = 16;  // Q0.16 result width
   localparam int NUM_CELLS = Q_W;  // one quotient bit per cell
   localparam int RECIP_W = 25;
   localparam int LUM_PROD_W = RAW_W + RECIP_W;

   // floor(2^32 / 255); the product shifted down by 32 is Yr/255 or one less
   localparam logic [RECIP_W-1:0] RECIP_255 = 25'd16843009;
   localparam int RECIP_SHIFT = 32;
   localparam logic [RAW_W-1:0] DIV_255 = 24'd255;

   // Q0.16 matrix, rows X, Y, Z, columns red, green, blue
   localparam logic [15:0] COEF [3][3] = '{
      '{16'd33694, 16'd21226, 16'd10510},
      '{16'd17371, 16'd43924, 16'd4200},
      '{16'd1581,  16'd8049,  16'd55340}
   };

   // word handed from cell to cell
   typedef struct packed {
      logic             black;
      logic [Q_W-1:0]   lum;
      logic [SUM_W-1:0] rem_x;
      logic [SUM_W-1:0] rem_y;
      logic [SUM_W-1:0] divisor;
      logic [Q_W-1:0]   quo_x;
      logic [Q_W-1:0]   quo_y;
   } cell_data_type;

endpackage

// File: design/ryc_if.sv
// Valid/ready stream interfaces for the pixel input and the xyY result.
// Depends on ryc_pkg for field widths.
interface ryc_pixel_if;
   logic                      valid;
   logic                      ready;
   logic [ryc_pkg::CH_W-1:0]  red;
   logic [ryc_pkg::CH_W-1:0]  green;
   logic [ryc_pkg::CH_W-1:0]  blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface ryc_yxy_if;
   logic                     valid;
   logic                     ready;
   logic [ryc_pkg::Q_W-1:0]  luminance;
   logic [ryc_pkg::Q_W-1:0]  chroma_x;
   logic [ryc_pkg::Q_W-1:0]  chroma_y;

   modport source (output valid, luminance, chroma_x, chroma_y, input ready);
   modport sink   (input valid, luminance, chroma_x, chroma_y, output ready);
endinterface

// File: design/ryc_front.sv
// Front end: 3x3 matrix to raw X, Y, Z sums, then luminance = Yr / 255 by reciprocal.
// Three register stages; emits the first word for the divider cell row. Uses ryc_pkg.
module ryc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      in_valid,
   input  logic [ryc_pkg::CH_W-1:0]  red,
   input  logic [ryc_pkg::CH_W-1:0]  green,
   input  logic [ryc_pkg::CH_W-1:0]  blue,
   output logic                      out_valid,
   output ryc_pkg::cell_data_type    out_data
);
   import ryc_pkg::*;

   logic [SUM_W-1:0]      row_x_wide;
   logic [SUM_W-1:0]      row_y_wide;
   logic [SUM_W-1:0]      row_z_wide;
   logic [RAW_W-1:0]      xr_in;
   logic [RAW_W-1:0]      yr_in;
   logic [SUM_W-1:0]      sum_in;
   logic [RAW_W-1:0]      xr_ff, yr_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic                  v1_ff;

   logic [LUM_PROD_W-1:0] lum_prod;
   logic [Q_W-1:0]        est_in;
   logic [Q_W-1:0]        est_ff;
   logic [RAW_W-1:0]      xr2_ff, yr2_ff;
   logic [SUM_W-1:0]      sum2_ff;
   logic                  v2_ff;

   logic [RAW_W-1:0]      est_times_255;
   logic [RAW_W-1:0]      lum_rem;
   logic [Q_W-1:0]        lum_in;
   cell_data_type         data_in;
   cell_data_type         data_ff;
   logic                  v3_ff;

   // stage 1: matrix rows
   always_comb begin
      row_x_wide = SUM_W'(COEF[0][0]) * SUM_W'(red) + SUM_W'(COEF[0][1]) * SUM_W'(green)
                 + SUM_W'(COEF[0][2]) * SUM_W'(blue);
      row_y_wide = SUM_W'(COEF[1][0]) * SUM_W'(red) + SUM_W'(COEF[1][1]) * SUM_W'(green)
                 + SUM_W'(COEF[1][2]) * SUM_W'(blue);
      row_z_wide = SUM_W'(COEF[2][0]) * SUM_W'(red) + SUM_W'(COEF[2][1]) * SUM_W'(green)
                 + SUM_W'(COEF[2][2]) * SUM_W'(blue);
      // each row stays below 2^24
      xr_in  = row_x_wide[RAW_W-1:0];
      yr_in  = row_y_wide[RAW_W-1:0];
      sum_in = row_x_wide + row_y_wide + row_z_wide;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
      end
      if (enable) begin
         xr_ff  <= xr_in;
         yr_ff  <= yr_in;
         sum_ff <= sum_in;
      end
   end

   // stage 2: reciprocal multiply, estimate is exact or one low
   always_comb begin
      lum_prod = LUM_PROD_W'(yr_ff) * LUM_PROD_W'(RECIP_255);
      est_in   = lum_prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (enable) begin
         v2_ff <= v1_ff;
      end
      if (enable) begin
         est_ff  <= est_in;
         xr2_ff  <= xr_ff;
         yr2_ff  <= yr_ff;
         sum2_ff <= sum_ff;
      end
   end

   // stage 3: correct the estimate and load the first cell word
   always_comb begin
      est_times_255 = RAW_W'({est_ff, 8'h00}) - RAW_W'(est_ff);
      lum_rem       = yr2_ff - est_times_255;
      lum_in        = (lum_rem >= DIV_255) ? est_ff + 1'b1 : est_ff;
      data_in.black   = (sum2_ff == '0);
      data_in.lum     = lum_in;
      data_in.rem_x   = SUM_W'(xr2_ff);
      data_in.rem_y   = SUM_W'(yr2_ff);
      data_in.divisor = sum2_ff;
      data_in.quo_x   = '0;
      data_in.quo_y   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (enable) begin
         v3_ff <= v2_ff;
      end
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = data_ff;

endmodule

// File: design/ryc_div_cell.sv
// One restoring-division cell: one quotient bit each for x and y per word.
// Uses ryc_pkg for the cell word type.
module ryc_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  ryc_pkg::cell_data_type  in_data,
   output logic                    out_valid,
   output ryc_pkg::cell_data_type  out_data
);
   import ryc_pkg::*;

   logic          valid_ff;
   cell_data_type data_ff;
   cell_data_type data_in;
   logic [SUM_W:0] shift_x, shift_y, div_ext;
   logic           ge_x, ge_y;
   logic [SUM_W:0] diff_x, diff_y;

   always_comb begin
      div_ext = {1'b0, in_data.divisor};
      shift_x = {in_data.rem_x, 1'b0};
      shift_y = {in_data.rem_y, 1'b0};
      ge_x    = (shift_x >= div_ext);
      ge_y    = (shift_y >= div_ext);
      diff_x  = shift_x - div_ext;
      diff_y  = shift_y - div_ext;
      data_in = in_data;
      // remainder stays below the divisor, so it fits back in SUM_W bits
      data_in.rem_x = ge_x ? diff_x[SUM_W-1:0] : shift_x[SUM_W-1:0];
      data_in.rem_y = ge_y ? diff_y[SUM_W-1:0] : shift_y[SUM_W-1:0];
      data_in.quo_x = {in_data.quo_x[Q_W-2:0], ge_x};
      data_in.quo_y = {in_data.quo_y[Q_W-2:0], ge_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: design/rgb_to_yxy_converter.sv
// RGB to CIE xyY converter. Takes one 8-bit RGB pixel per clock and returns luminance Y and
// chromaticities x and y, all unsigned Q0.16. Sustained rate is one pixel per clock unless the
// output stalls. Three front stages (matrix, reciprocal multiply for Y/255, correction) feed a
// row of 16 division cells that each produce one quotient bit of x and y. The last cell is the
// output register; when the sink stalls it, the whole pipe holds, and it keeps taking pixels
// as long as the output is empty or being taken. A black pixel gives all-zero results.
// Depends on ryc_pkg, ryc_if, ryc_front and ryc_div_cell.
module rgb_to_yxy_converter (
   input  logic         clock,
   input  logic         reset,
   ryc_pixel_if.sink    req_chan,
   ryc_yxy_if.source    rsp_chan
);
   import ryc_pkg::*;

   logic          enable;
   logic          cell_valid [NUM_CELLS+1];
   cell_data_type cell_data  [NUM_CELLS+1];

   // advance everything unless a finished word is stuck at the output
   assign enable         = !cell_valid[NUM_CELLS] || rsp_chan.ready;
   assign req_chan.ready = enable;

   ryc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_chan.valid),
      .red       (req_chan.red),
      .green     (req_chan.green),
      .blue      (req_chan.blue),
      .out_valid (cell_valid[0]),
      .out_data  (cell_data[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      ryc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (cell_valid[i]),
         .in_data   (cell_data[i]),
         .out_valid (cell_valid[i+1]),
         .out_data  (cell_data[i+1])
      );
   end

   assign rsp_chan.valid     = cell_valid[NUM_CELLS];
   assign rsp_chan.luminance = cell_data[NUM_CELLS].lum;
   // black pixel: the divider sees 0/0, drop its quotient
   assign rsp_chan.chroma_x  = cell_data[NUM_CELLS].black ? '0 : cell_data[NUM_CELLS].quo_x;
   assign rsp_chan.chroma_y  = cell_data[NUM_CELLS].black ? '0 : cell_data[NUM_CELLS].quo_y;

endmodule

// File: design/ryc_checker.sv
// Port-level checks for the RGB to xyY converter, bound to the top level.
// Depends on rgb_to_yxy_converter_defines.svh and ryc_pkg.
`include "rgb_to_yxy_converter_defines.svh"

module ryc_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [ryc_pkg::Q_W-1:0]  luminance,
   input logic [ryc_pkg::Q_W-1:0]  chroma_x,
   input logic [ryc_pkg::Q_W-1:0]  chroma_y
);
   import ryc_pkg::*;

   logic [Q_W:0] chroma_sum;

   assign chroma_sum = {1'b0, chroma_x} + {1'b0, chroma_y};

   `RYC_ASSERT_ALWAYS(a_no_word_after_reset, $past(reset), !rsp_valid, "result word right after reset")
   `RYC_ASSERT_NEXT(a_stall_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(luminance) && $stable(chroma_x) && $stable(chroma_y), "stalled result word changed")
   `RYC_ASSERT_NOW(a_chroma_bound, rsp_valid, chroma_sum <= {1'b1, {Q_W{1'b0}}}, "x + y exceeds one")
   `RYC_ASSERT_NOW(a_black_zero, rsp_valid && luminance == '0, chroma_x == '0 && chroma_y == '0, "zero luminance with nonzero chroma")
   `RYC_ASSERT_NOW(a_ready_on_stall, rsp_valid && !rsp_ready, !req_ready, "input taken while output stalled")

endmodule

bind rgb_to_yxy_converter ryc_checker u_ryc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .luminance (rsp_chan.luminance),
   .chroma_x  (rsp_chan.chroma_x),
   .chroma_y  (rsp_chan.chroma_y)
);
